>>> rtl/ddlm_pkg.sv
`default_nettype none

package ddlm_pkg;

    // Action codes carried in the input tuser
    localparam logic [1:0] ACT_UP     = 2'd0;
    localparam logic [1:0] ACT_DOWN   = 2'd1;
    localparam logic [1:0] ACT_REDRAW = 2'd2;
    localparam logic [1:0] ACT_SPARE  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_RED    = 1'b1;

    // Register reset values; 178 is 0.7 of full scale, truncated
    localparam logic [31:0] WINDOW_RESET = 32'd200000;
    localparam logic [7:0]  RED_RESET    = 8'd178;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [3:0] DIGIT_MIN = 4'd0;

    // Matrix geometry: 5 rows of 5 pixels, counters index 0..4
    localparam logic [2:0] DIM_LAST = 3'd4;

    // Bit position of the red byte inside a pixel word
    localparam int RED_LSB = 24;

    localparam int PIXEL_W = 32;
    localparam int DIGIT_W = 4;
    localparam int OUT_TDATA_W = 40;

    // One frame request handed from front to back
    typedef struct packed {
        logic [3:0] digit;
    } t_frame_req;

    // Font rows: bit 4 is the leftmost column
    function automatic logic [4:0] font_row(input logic [3:0] d, input logic [2:0] row);
        logic [24:0] glyph;
        begin
            case (d)
                4'd0:    glyph = {5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F};
                4'd1:    glyph = {5'h04, 5'h0C, 5'h14, 5'h04, 5'h0E};
                4'd2:    glyph = {5'h1F, 5'h01, 5'h1F, 5'h10, 5'h1F};
                4'd3:    glyph = {5'h1F, 5'h01, 5'h1F, 5'h01, 5'h1F};
                4'd4:    glyph = {5'h11, 5'h11, 5'h1F, 5'h01, 5'h01};
                4'd5:    glyph = {5'h1F, 5'h10, 5'h1F, 5'h01, 5'h1F};
                4'd6:    glyph = {5'h1F, 5'h10, 5'h1F, 5'h11, 5'h1F};
                4'd7:    glyph = {5'h1F, 5'h02, 5'h04, 5'h08, 5'h10};
                4'd8:    glyph = {5'h1F, 5'h11, 5'h1F, 5'h11, 5'h1F};
                default: glyph = {5'h1F, 5'h11, 5'h1F, 5'h01, 5'h01};
            endcase
            // row 0 sits in the top bits of the packed glyph
            case (row)
                3'd0:    font_row = glyph[24:20];
                3'd1:    font_row = glyph[19:15];
                3'd2:    font_row = glyph[14:10];
                3'd3:    font_row = glyph[9:5];
                default: font_row = glyph[4:0];
            endcase
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/ddlm_front.sv
`default_nettype none

module ddlm_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic [1:0]             i_action,
    input  wire logic [31:0]            i_timestamp_us,
    input  wire logic [31:0]            i_window,
    output      ddlm_pkg::t_frame_req   o_req
);

    logic [3:0]  r_digit, n_digit;
    logic [31:0] r_last_up, n_last_up;
    logic [31:0] r_last_down, n_last_down;
    logic [31:0] w_ref_time;
    logic [31:0] w_elapsed;
    logic        w_pass;

    // Pick the timer of the pressed button and measure the wrapping gap
    assign w_ref_time = (i_action == ddlm_pkg::ACT_DOWN) ? r_last_down : r_last_up;
    assign w_elapsed  = i_timestamp_us - w_ref_time;
    assign w_pass     = (w_elapsed > i_window);

    // Classify the request and step the digit
    always_comb begin
        n_digit     = r_digit;
        n_last_up   = r_last_up;
        n_last_down = r_last_down;
        if (i_accept && w_pass) begin
            unique case (i_action)
                ddlm_pkg::ACT_UP: begin
                    n_last_up = i_timestamp_us;
                    if (r_digit < ddlm_pkg::DIGIT_MAX) n_digit = r_digit + 4'd1;
                end
                ddlm_pkg::ACT_DOWN: begin
                    n_last_down = i_timestamp_us;
                    if (r_digit > ddlm_pkg::DIGIT_MIN) n_digit = r_digit - 4'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit     <= ddlm_pkg::DIGIT_MIN;
            r_last_up   <= '0;
            r_last_down <= '0;
        end else begin
            r_digit     <= n_digit;
            r_last_up   <= n_last_up;
            r_last_down <= n_last_down;
        end
    end

    // The queued frame shows the digit after this request
    assign o_req.digit = n_digit;

endmodule

`default_nettype wire

>>> rtl/ddlm_queue.sv
`default_nettype none

module ddlm_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire ddlm_pkg::t_frame_req   i_data,
    output      logic                   o_full,
    input  wire logic                   i_pop,
    output      logic                   o_valid,
    output      ddlm_pkg::t_frame_req   o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    ddlm_pkg::t_frame_req r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    // Store the request at the write pointer
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and track the fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + AW'(1);
            if (i_pop)  r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + AW'(1);
            if (i_push && !i_pop)      r_count <= r_count + CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - CW'(1);
        end
    end

endmodule

`default_nettype wire

>>> rtl/ddlm_back.sv
`default_nettype none

module ddlm_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_req_valid,
    input  wire ddlm_pkg::t_frame_req   i_req,
    output      logic                   o_req_pop,
    input  wire logic [7:0]             i_red_level,
    output      logic                   o_tvalid,
    input  wire logic                   i_tready,
    output      logic [ddlm_pkg::OUT_TDATA_W-1:0] o_tdata,
    output      logic                   o_tlast
);

    logic       r_busy;
    logic [3:0] r_digit;
    logic [2:0] r_j;
    logic [2:0] r_k;
    logic       r_out_valid;
    logic [31:0] r_out_word;
    logic [3:0] r_out_digit;
    logic       r_out_last;

    logic       w_advance;
    logic       w_emit;
    logic       w_frame_end;
    logic [2:0] w_row;
    logic [2:0] w_bit;
    logic [4:0] w_font;
    logic       w_lit;
    logic       w_last;

    // Output register frees when empty or taken
    assign w_advance   = !r_out_valid || i_tready;
    assign w_emit      = w_advance && r_busy;
    assign w_last      = (r_j == ddlm_pkg::DIM_LAST) && (r_k == ddlm_pkg::DIM_LAST);
    assign w_frame_end = w_emit && w_last;
    assign o_req_pop   = i_req_valid && (!r_busy || w_frame_end);

    // Serpentine scan: bottom font row first, direction flips each row
    assign w_row  = ddlm_pkg::DIM_LAST - r_j;
    assign w_bit  = r_j[0] ? (ddlm_pkg::DIM_LAST - r_k) : r_k;
    assign w_font = ddlm_pkg::font_row(r_digit, w_row);
    assign w_lit  = w_font[w_bit];

    // Walk the frame, chaining straight into the next queued request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_j    <= '0;
            r_k    <= '0;
        end else if (o_req_pop) begin
            r_busy <= 1'b1;
            r_j    <= '0;
            r_k    <= '0;
        end else if (w_frame_end) begin
            r_busy <= 1'b0;
        end else if (w_emit) begin
            if (r_k == ddlm_pkg::DIM_LAST) begin
                r_k <= '0;
                r_j <= r_j + 3'd1;
            end else begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) r_digit <= i_req.digit;
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_word  <= w_lit ? {i_red_level, 24'd0} : 32'd0;
            r_out_digit <= r_digit;
            r_out_last  <= w_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {4'd0, r_out_digit, r_out_word};
    assign o_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> rtl/debounced_digit_led_matrix.sv
// Channel   Dir  Handshake              Payload
// s_axis    in   i_s_tvalid/o_s_tready  tdata: timestamp_us; tuser: action
// m_axis    out  o_m_tvalid/i_m_tready  tdata: pixel_word, digit_shown; tlast: last_pixel
// cfg       in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// Each request produces a frame of 25 pixels, one per cycle while m_axis is not
// stalled, a rate set by the single-pixel scan of the back end.
// The front end takes one request per cycle while the request queue has room.
// Frames follow each other without a gap; queue, scan and output stage register them.
// Reset is synchronous; it restores both registers, clears the digit and timers.
// A stall on m_axis holds the scan; s_axis keeps flowing until the queue fills.
`default_nettype none

module debounced_digit_led_matrix #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] timestamp_us
    input  wire logic [1:0]  i_s_tuser,   // [1:0] action
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [39:0] o_m_tdata,   // [31:0] pixel_word, [35:32] digit_shown
    output      logic        o_m_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    logic [31:0] r_window;
    logic [7:0]  r_red_level;
    logic        w_accept;
    logic        w_full;
    logic        w_pop;
    logic        w_req_valid;
    ddlm_pkg::t_frame_req w_push_req;
    ddlm_pkg::t_frame_req w_pop_req;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= ddlm_pkg::WINDOW_RESET;
            r_red_level <= ddlm_pkg::RED_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ddlm_pkg::CFG_WINDOW: r_window    <= i_cfg_data;
                ddlm_pkg::CFG_RED:    r_red_level <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_s_tready = !w_full;
    assign w_accept   = i_s_tvalid && !w_full;

    ddlm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_action       (i_s_tuser),
        .i_timestamp_us (i_s_tdata),
        .i_window       (r_window),
        .o_req          (w_push_req)
    );

    ddlm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_push_req),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_req_valid),
        .o_data  (w_pop_req)
    );

    ddlm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_pop_req),
        .o_req_pop   (w_pop),
        .i_red_level (r_red_level),
        .o_tvalid    (o_m_tvalid),
        .i_tready    (i_m_tready),
        .o_tdata     (o_m_tdata),
        .o_tlast     (o_m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/ddlm_checker.sv
`default_nettype none

module ddlm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata,
    input wire logic        o_m_tlast
);

    // A stalled pixel holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    // Shown digit stays in 0..9
    a_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[35:32] <= 4'd9))
        else $error("digit out of range");

    // Only the red byte and digit carry data
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[23:0] == 24'd0) && (o_m_tdata[39:36] == 4'd0))
        else $error("reserved pixel bits set");

    // Reset empties the output stage
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind debounced_digit_led_matrix ddlm_checker u_ddlm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
